>>> hw/rtl/mdd_pkg.sv
package mdd_pkg;

   // Sample and reading widths
   localparam int DATA_BITS    = 13;
   localparam int SAMPLE_BITS  = 3;
   localparam int SAMPLES      = 1 << SAMPLE_BITS;
   localparam int SUM_BITS     = DATA_BITS + SAMPLE_BITS;

   // Ring store geometry
   localparam int SLOT_BITS    = 5;
   localparam int NUM_SLOTS    = 1 << SLOT_BITS;
   localparam int SCAN_BITS    = DATA_BITS + SLOT_BITS;

   // Squared-difference accumulation and root
   localparam int SQ_TERM_BITS = 2 * DATA_BITS;
   localparam int SQ_BITS      = SQ_TERM_BITS + SLOT_BITS;
   localparam int ROOT_BITS    = DATA_BITS;
   localparam int RAD_BITS     = 2 * ROOT_BITS;
   localparam int REM_BITS     = ROOT_BITS + 3;
   localparam int STEP_BITS    = $clog2(ROOT_BITS);

   // Band edges
   localparam int GAIN_BITS    = 4;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 4'd2;
   localparam int PROD_BITS    = GAIN_BITS + ROOT_BITS;
   localparam int EDGE_BITS    = 18;

   // Stream widths
   localparam int OPCODE_BITS   = 2;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_FIELD_BITS = 5 * DATA_BITS + 2 + 2 * EDGE_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_FIELD_BITS;
   localparam int RSP_DIST_BIT  = DATA_BITS;
   localparam int RSP_START_BIT = DATA_BITS + 1;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_SAMPLE    = 2'd0,
      OP_RECOMPUTE = 2'd1,
      OP_RESTART   = 2'd2
   } opcode_type;

   localparam logic KIND_READING = 1'b0;
   localparam logic KIND_STATS   = 1'b1;

   // Status from the root unit back to the sequencer
   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] ceil_root;
   } root_stat_type;

endpackage

>>> hw/rtl/mdd_isqrt.sv
module mdd_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mdd_pkg::RAD_BITS-1:0]   radicand,
   output mdd_pkg::root_stat_type         stat
);

   logic [mdd_pkg::RAD_BITS-1:0]  q_ff, q_in;
   logic [mdd_pkg::REM_BITS-1:0]  rem_ff, rem_in;
   logic [mdd_pkg::ROOT_BITS-1:0] root_ff, root_in;
   logic [mdd_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [mdd_pkg::REM_BITS-1:0]  rem_shift;
   logic [mdd_pkg::REM_BITS-1:0]  trial;
   logic                          take;

   // One result bit per cycle, two radicand bits brought down each step
   always_comb begin
      rem_shift = {rem_ff[mdd_pkg::REM_BITS-3:0], q_ff[mdd_pkg::RAD_BITS-1 -: 2]};
      trial     = mdd_pkg::REM_BITS'({root_ff, 2'b01});
      take      = (rem_shift >= trial);
      q_in      = q_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         q_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in    = q_ff << 2;
         rem_in  = take ? (rem_shift - trial) : rem_shift;
         root_in = {root_ff[mdd_pkg::ROOT_BITS-2:0], take};
         step_in = step_ff + 1'b1;
         if (step_ff == mdd_pkg::STEP_BITS'(mdd_pkg::ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // Round up when the remainder shows the square fell short
   assign stat.done      = done_ff;
   assign stat.ceil_root = root_ff + mdd_pkg::ROOT_BITS'(rem_ff != '0);

endmodule

>>> hw/rtl/magnetic_disturbance_detector.sv
// Magnetic disturbance detector.
//
// Requests arrive on req_*: req_tuser carries the opcode (sample, recompute,
// restart), req_tdata the signed raw z sample. Every eighth sample completes
// a reading, which is returned on rsp_* with rsp_tuser = 0; a recompute
// request returns the fresh statistics with rsp_tuser = 1. Partial samples,
// restarts and the unused opcode return nothing.
// The block handles one request at a time. A sample that does not complete a
// reading leaves the block ready. A completed reading passes the reading and
// emit states, and the block is ready again in the cycle it is presented. A
// recompute walks the 32-entry store twice through its single read port,
// then runs a 13-step bit-serial root and forms the band edges before the
// result is emitted; the last reading of the startup fill does the same.
// The result sits in an output register: if rsp_tready is low the block
// still accepts requests that give no result, and holds the next result
// in its final step until the register frees up. Synchronous reset enters
// startup fill, clears the statistics, the band and the output valid, and
// sets the deviation gain to 2. Store contents are not cleared; the user
// must let startup fill all entries before a read; the block does not check.
module magnetic_disturbance_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: raw_z[12:0], zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mdd_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // req_tuser: opcode[1:0]
   input  logic [mdd_pkg::OPCODE_BITS-1:0]      req_tuser,
   // rsp_tdata: reading, disturbance, starting_up, mean_value, deviation,
   //            min_value, max_value, band_low, band_high, zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mdd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // rsp_tuser: result_kind
   output logic                                 rsp_tuser,
   input  logic                                 csr_wr_en,
   input  logic [mdd_pkg::GAIN_BITS-1:0]        csr_wr_data
);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_READING = 11'b000_0000_0010,
      ST_SCAN1   = 11'b000_0000_0100,
      ST_END1    = 11'b000_0000_1000,
      ST_MEAN    = 11'b000_0001_0000,
      ST_SCAN2   = 11'b000_0010_0000,
      ST_END2    = 11'b000_0100_0000,
      ST_ROOT    = 11'b000_1000_0000,
      ST_BAND    = 11'b001_0000_0000,
      ST_EDGE    = 11'b010_0000_0000,
      ST_EMIT    = 11'b100_0000_0000
   } state_type;

   localparam int DB = mdd_pkg::DATA_BITS;
   localparam int EB = mdd_pkg::EDGE_BITS;

   // Control state
   state_type                          state_ff, state_in;
   logic [mdd_pkg::GAIN_BITS-1:0]      gain_ff, gain_in;
   logic signed [mdd_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [mdd_pkg::SAMPLE_BITS-1:0]    cnt_ff, cnt_in;
   logic [mdd_pkg::SLOT_BITS-1:0]      oldest_ff, oldest_in;
   logic [mdd_pkg::SLOT_BITS-1:0]      fill_ff, fill_in;
   logic                               startup_ff, startup_in;
   logic signed [DB-1:0]               last_ff, last_in;
   logic signed [DB-1:0]               mean_ff, mean_in;
   logic [mdd_pkg::ROOT_BITS-1:0]      dev_ff, dev_in;
   logic signed [DB-1:0]               min_ff, min_in;
   logic signed [DB-1:0]               max_ff, max_in;
   logic signed [EB-1:0]               elow_ff, elow_in;
   logic signed [EB-1:0]               ehigh_ff, ehigh_in;
   logic [mdd_pkg::SLOT_BITS-1:0]      idx_ff, idx_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic                               rd_first_ff, rd_first_in;
   logic                               rd_sq_ff, rd_sq_in;
   logic                               sq_vld_ff, sq_vld_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // Per-request flags and datapath
   logic                               kind_ff, kind_in;
   logic                               dist_ff, dist_in;
   logic                               start_ff, start_in;
   logic signed [mdd_pkg::SCAN_BITS-1:0] scan_sum_ff, scan_sum_in;
   logic signed [DB-1:0]               scan_min_ff, scan_min_in;
   logic signed [DB-1:0]               scan_max_ff, scan_max_in;
   logic [mdd_pkg::SQ_TERM_BITS-1:0]   sq_term_ff, sq_term_in;
   logic [mdd_pkg::SQ_BITS-1:0]        sq_sum_ff, sq_sum_in;
   logic [mdd_pkg::PROD_BITS-1:0]      prod_ff, prod_in;
   logic                               rsp_kind_ff, rsp_kind_in;
   logic [mdd_pkg::RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;

   // Store
   logic [DB-1:0]                      store_mem [mdd_pkg::NUM_SLOTS];
   logic signed [DB-1:0]               rd_data_ff;
   logic [mdd_pkg::SLOT_BITS-1:0]      rd_addr;
   logic                               wr_en;
   logic [mdd_pkg::SLOT_BITS-1:0]      wr_addr;

   // Combinational helpers
   logic                               req_fire;
   mdd_pkg::opcode_type                opcode;
   logic signed [DB-1:0]               raw_z;
   logic signed [mdd_pkg::SUM_BITS-1:0] sum_next;
   logic signed [mdd_pkg::SUM_BITS-1:0] sum_adj;
   logic signed [mdd_pkg::SCAN_BITS-1:0] scan_adj;
   logic signed [EB-1:0]               r_ext;
   logic                               in_band;
   logic                               in_strict;
   logic signed [DB:0]                 diff;
   logic signed [2*DB+1:0]             diff_ext;
   logic signed [2*DB+1:0]             square;
   logic [mdd_pkg::SQ_BITS:0]          sq_round;
   logic                               root_start;
   logic [mdd_pkg::RAD_BITS-1:0]       radicand;
   mdd_pkg::root_stat_type             root_stat;
   logic                               emit_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign opcode     = mdd_pkg::opcode_type'(req_tuser);
   assign raw_z      = $signed(req_tdata[DB-1:0]);

   // Reading: group sum divided by the group size, truncated toward zero
   assign sum_next = sum_ff + $signed({{mdd_pkg::SAMPLE_BITS{raw_z[DB-1]}}, raw_z});
   assign sum_adj  = sum_next + (sum_next[mdd_pkg::SUM_BITS-1] ?
                     mdd_pkg::SUM_BITS'(mdd_pkg::SAMPLES - 1) : '0);

   // Mean: store sum divided by the slot count, truncated toward zero
   assign scan_adj = scan_sum_ff + (scan_sum_ff[mdd_pkg::SCAN_BITS-1] ?
                     mdd_pkg::SCAN_BITS'(mdd_pkg::NUM_SLOTS - 1) : '0);

   // Band tests on the latest reading
   assign r_ext     = $signed({{(EB-DB){last_ff[DB-1]}}, last_ff});
   assign in_band   = (elow_ff <= r_ext) && (r_ext <= ehigh_ff);
   assign in_strict = (elow_ff < r_ext) && (r_ext < ehigh_ff);

   // Squared difference from the mean
   assign diff     = $signed({rd_data_ff[DB-1], rd_data_ff}) - $signed({mean_ff[DB-1], mean_ff});
   assign diff_ext = $signed({{(DB+1){diff[DB]}}, diff});
   assign square   = diff_ext * diff_ext;

   // Radicand: sum of squares over slot count, rounded up
   assign sq_round = {1'b0, sq_sum_ff} + (mdd_pkg::SQ_BITS+1)'(mdd_pkg::NUM_SLOTS - 1);
   assign radicand = mdd_pkg::RAD_BITS'(sq_round >> mdd_pkg::SLOT_BITS);

   assign rd_addr = idx_ff;
   assign wr_addr = oldest_ff;

   mdd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .stat     (root_stat)
   );

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      gain_in      = csr_wr_en ? csr_wr_data : gain_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      oldest_in    = oldest_ff;
      fill_in      = fill_ff;
      startup_in   = startup_ff;
      last_in      = last_ff;
      mean_in      = mean_ff;
      dev_in       = dev_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      elow_in      = elow_ff;
      ehigh_in     = ehigh_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      rd_first_in  = 1'b0;
      rd_sq_in     = 1'b0;
      sq_vld_in    = 1'b0;
      kind_in      = kind_ff;
      dist_in      = dist_ff;
      start_in     = start_ff;
      scan_sum_in  = scan_sum_ff;
      scan_min_in  = scan_min_ff;
      scan_max_in  = scan_max_ff;
      sq_term_in   = sq_term_ff;
      sq_sum_in    = sq_sum_ff;
      prod_in      = prod_ff;
      wr_en        = 1'b0;
      root_start   = 1'b0;
      emit_load    = 1'b0;

      // Pass one: sum, min and max, seeded from slot zero
      if (rd_vld_ff && !rd_sq_ff) begin
         if (rd_first_ff) begin
            scan_sum_in = $signed({{mdd_pkg::SLOT_BITS{rd_data_ff[DB-1]}}, rd_data_ff});
            scan_min_in = rd_data_ff;
            scan_max_in = rd_data_ff;
         end else begin
            scan_sum_in = scan_sum_ff +
                          $signed({{mdd_pkg::SLOT_BITS{rd_data_ff[DB-1]}}, rd_data_ff});
            if (rd_data_ff < scan_min_ff) begin
               scan_min_in = rd_data_ff;
            end
            if (rd_data_ff > scan_max_ff) begin
               scan_max_in = rd_data_ff;
            end
         end
      end

      // Pass two: register the square, then accumulate it
      if (rd_vld_ff && rd_sq_ff) begin
         sq_term_in = mdd_pkg::SQ_TERM_BITS'(square);
         sq_vld_in  = 1'b1;
      end
      if (sq_vld_ff) begin
         sq_sum_in = sq_sum_ff + mdd_pkg::SQ_BITS'(sq_term_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (opcode)
                  mdd_pkg::OP_SAMPLE: begin
                     if (cnt_ff == mdd_pkg::SAMPLE_BITS'(mdd_pkg::SAMPLES - 1)) begin
                        last_in  = DB'(sum_adj >>> mdd_pkg::SAMPLE_BITS);
                        sum_in   = '0;
                        cnt_in   = '0;
                        state_in = ST_READING;
                     end else begin
                        sum_in = sum_next;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  mdd_pkg::OP_RECOMPUTE: begin
                     kind_in  = mdd_pkg::KIND_STATS;
                     dist_in  = 1'b0;
                     start_in = startup_ff;
                     idx_in   = '0;
                     state_in = ST_SCAN1;
                  end
                  mdd_pkg::OP_RESTART: begin
                     startup_in = 1'b1;
                     oldest_in  = '0;
                     fill_in    = '0;
                     sum_in     = '0;
                     cnt_in     = '0;
                     last_in    = '0;
                     mean_in    = '0;
                     dev_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READING: begin
            kind_in = mdd_pkg::KIND_READING;
            if (startup_ff) begin
               // Store unchecked; a full store ends startup with a recompute
               wr_en     = 1'b1;
               oldest_in = oldest_ff + 1'b1;
               dist_in   = 1'b0;
               start_in  = 1'b1;
               if (fill_ff == mdd_pkg::SLOT_BITS'(mdd_pkg::NUM_SLOTS - 1)) begin
                  fill_in    = '0;
                  startup_in = 1'b0;
                  idx_in     = '0;
                  state_in   = ST_SCAN1;
               end else begin
                  fill_in  = fill_ff + 1'b1;
                  state_in = ST_EMIT;
               end
            end else begin
               wr_en     = in_band;
               oldest_in = in_band ? oldest_ff + 1'b1 : oldest_ff;
               dist_in   = ~in_strict;
               start_in  = 1'b0;
               state_in  = ST_EMIT;
            end
         end
         ST_SCAN1: begin
            rd_vld_in   = 1'b1;
            rd_first_in = (idx_ff == '0);
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == mdd_pkg::SLOT_BITS'(mdd_pkg::NUM_SLOTS - 1)) begin
               state_in = ST_END1;
            end
         end
         ST_END1: begin
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            mean_in   = DB'(scan_adj >>> mdd_pkg::SLOT_BITS);
            sq_sum_in = '0;
            idx_in    = '0;
            state_in  = ST_SCAN2;
         end
         ST_SCAN2: begin
            rd_vld_in = 1'b1;
            rd_sq_in  = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == mdd_pkg::SLOT_BITS'(mdd_pkg::NUM_SLOTS - 1)) begin
               state_in = ST_END2;
            end
         end
         ST_END2: begin
            // Wait for the square pipeline to drain
            if (!rd_vld_ff && !sq_vld_ff) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_stat.done) begin
               dev_in   = root_stat.ceil_root;
               state_in = ST_BAND;
            end
         end
         ST_BAND: begin
            prod_in  = mdd_pkg::PROD_BITS'(gain_ff) * mdd_pkg::PROD_BITS'(dev_ff);
            min_in   = scan_min_ff;
            max_in   = scan_max_ff;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            elow_in  = $signed({{(EB-DB){min_ff[DB-1]}}, min_ff}) - $signed({1'b0, prod_ff});
            ehigh_in = $signed({{(EB-DB){max_ff[DB-1]}}, max_ff}) + $signed({1'b0, prod_ff});
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               emit_load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Output register: load a result, drop it once taken
      rsp_valid_in = emit_load | (rsp_valid_ff & ~rsp_tready);
      rsp_kind_in  = emit_load ? kind_ff : rsp_kind_ff;
      rsp_data_in  = emit_load ?
                     {{mdd_pkg::RSP_PAD_BITS{1'b0}}, ehigh_ff, elow_ff, max_ff, min_ff,
                      dev_ff, mean_ff, start_ff, dist_ff, last_ff} :
                     rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= mdd_pkg::GAIN_RESET;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         oldest_ff    <= '0;
         fill_ff      <= '0;
         startup_ff   <= 1'b1;
         last_ff      <= '0;
         mean_ff      <= '0;
         dev_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         elow_ff      <= '0;
         ehigh_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rd_first_ff  <= 1'b0;
         rd_sq_ff     <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         oldest_ff    <= oldest_in;
         fill_ff      <= fill_in;
         startup_ff   <= startup_in;
         last_ff      <= last_in;
         mean_ff      <= mean_in;
         dev_ff       <= dev_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         elow_ff      <= elow_in;
         ehigh_ff     <= ehigh_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rd_first_ff  <= rd_first_in;
         rd_sq_ff     <= rd_sq_in;
         sq_vld_ff    <= sq_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      dist_ff     <= dist_in;
      start_ff    <= start_in;
      scan_sum_ff <= scan_sum_in;
      scan_min_ff <= scan_min_in;
      scan_max_ff <= scan_max_in;
      sq_term_ff  <= sq_term_in;
      sq_sum_ff   <= sq_sum_in;
      prod_ff     <= prod_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= last_ff;
      end
      rd_data_ff <= $signed(store_mem[rd_addr]);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/mdd_checker.sv
module mdd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [mdd_pkg::OPCODE_BITS-1:0]   req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mdd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                              rsp_tuser
);

   // Hold a stalled response unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed or dropped");

   // Drop any pending response on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Restart leaves the block ready in the next cycle
   a_restart_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == mdd_pkg::OP_RESTART |=> req_tready)
      else $error("restart request stalled the block");

   // Recompute keeps the block busy
   a_recompute_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == mdd_pkg::OP_RECOMPUTE |=> !req_tready)
      else $error("block ready right after a recompute request");

   // No disturbance on statistics or startup readings
   a_no_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mdd_pkg::KIND_STATS || rsp_tdata[mdd_pkg::RSP_START_BIT])
      |-> !rsp_tdata[mdd_pkg::RSP_DIST_BIT])
      else $error("disturbance flagged on statistics or startup result");

endmodule

bind magnetic_disturbance_detector mdd_checker u_mdd_checker (.*);

>>> bench/magnetic_disturbance_detector_test.sv
module magnetic_disturbance_detector_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [mdd_pkg::OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_REPORTS  = 10;
   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 400;
   localparam int SAMPLE_MIN   = -4096;
   localparam int SAMPLE_MAX   = 4095;

   // Field offsets inside rsp_tdata
   localparam int MEAN_LSB  = mdd_pkg::RSP_START_BIT + 1;
   localparam int DEV_LSB   = MEAN_LSB + mdd_pkg::DATA_BITS;
   localparam int MIN_LSB   = DEV_LSB + mdd_pkg::DATA_BITS;
   localparam int MAX_LSB   = MIN_LSB + mdd_pkg::DATA_BITS;
   localparam int BLOW_LSB  = MAX_LSB + mdd_pkg::DATA_BITS;
   localparam int BHIGH_LSB = BLOW_LSB + mdd_pkg::EDGE_BITS;

   typedef struct {
      logic                                 kind;
      logic signed [mdd_pkg::DATA_BITS-1:0] reading;
      logic                                 disturbance;
      logic                                 starting_up;
      logic signed [mdd_pkg::DATA_BITS-1:0] mean_value;
      logic [mdd_pkg::DATA_BITS-1:0]        deviation;
      logic signed [mdd_pkg::DATA_BITS-1:0] min_value;
      logic signed [mdd_pkg::DATA_BITS-1:0] max_value;
      logic signed [mdd_pkg::EDGE_BITS-1:0] band_low;
      logic signed [mdd_pkg::EDGE_BITS-1:0] band_high;
   } detector_result_type;

   // One line of the directed script; value is the typed startup reading
   typedef struct {
      logic [mdd_pkg::OPCODE_BITS-1:0] op;
      int                              z;
      int                              reps;
      bit                              typed;
      int                              value;
   } script_row_type;

   localparam int SCRIPT_ROWS = 17;
   script_row_type script[SCRIPT_ROWS] = '{
      '{mdd_pkg::OP_SAMPLE,     4095,   8, 1'b1,  4095},  // top of sample range
      '{mdd_pkg::OP_SAMPLE,    -4096,   8, 1'b1, -4096},  // bottom of sample range
      '{mdd_pkg::OP_SAMPLE,    -4096,   4, 1'b0,     0},
      '{mdd_pkg::OP_SAMPLE,     4095,   4, 1'b1,     0},  // sum -4 truncates to zero
      '{OP_UNUSED,                -1,   1, 1'b0,     0},  // unused opcode is dropped
      '{mdd_pkg::OP_SAMPLE,     1234,   3, 1'b0,     0},  // partial group
      '{mdd_pkg::OP_RESTART,       0,   1, 1'b0,     0},  // restart discards it
      '{mdd_pkg::OP_SAMPLE,       -9,   1, 1'b0,     0},
      '{mdd_pkg::OP_SAMPLE,        0,   7, 1'b1,    -1},  // -9/8 truncates toward zero
      '{mdd_pkg::OP_SAMPLE,     1000, 240, 1'b0,     0},
      '{mdd_pkg::OP_SAMPLE,    -1000,   8, 1'b0,     0},  // last fill reading recomputes
      '{mdd_pkg::OP_SAMPLE,     4095,   8, 1'b0,     0},  // far outside the band
      '{mdd_pkg::OP_SAMPLE,      900,   8, 1'b0,     0},  // inside the band
      '{mdd_pkg::OP_RECOMPUTE,     0,   1, 1'b0,     0},
      '{mdd_pkg::OP_RESTART,       0,   1, 1'b0,     0},
      '{mdd_pkg::OP_RECOMPUTE,     0,   1, 1'b0,     0},  // recompute while filling
      '{OP_UNUSED,              4095,   1, 1'b0,     0}
   };

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [mdd_pkg::REQ_DATA_BITS-1:0]   req_tdata;
   logic [mdd_pkg::OPCODE_BITS-1:0]     req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [mdd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_wr_en;
   logic [mdd_pkg::GAIN_BITS-1:0]       csr_wr_data;

   // Detector state as predicted
   int ring[mdd_pkg::NUM_SLOTS] = '{default: 0};
   int write_slot      = 0;
   int fill_total      = 0;
   bit in_startup      = 1'b1;
   bit ring_full       = 1'b0;
   int group_sum       = 0;
   int group_count     = 0;
   int latest_reading  = 0;
   int mean_now        = 0;
   int spread_now      = 0;
   int low_now         = 0;
   int high_now        = 0;
   int floor_edge      = 0;
   int ceil_edge       = 0;
   int gain_now        = int'(mdd_pkg::GAIN_RESET);

   detector_result_type pending_results[$];
   int fault_count  = 0;
   int cycle_count  = 0;
   int send_idle    = 0;
   int rsp_stall    = 0;

   magnetic_disturbance_detector uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Statistics over the whole store, band from the current gain
   task automatic refresh_statistics();
      longint total;
      longint squares;
      longint diff;
      longint lo_root;
      longint hi_root;
      longint mid;
      int lo;
      int hi;
      total   = 0;
      squares = 0;
      lo      = ring[0];
      hi      = ring[0];
      for (int i = 0; i < mdd_pkg::NUM_SLOTS; i++) begin
         total += ring[i];
         if (ring[i] < lo) lo = ring[i];
         if (ring[i] > hi) hi = ring[i];
      end
      mean_now = int'(total / mdd_pkg::NUM_SLOTS);
      for (int i = 0; i < mdd_pkg::NUM_SLOTS; i++) begin
         diff = longint'(ring[i] - mean_now);
         squares += diff * diff;
      end
      // smallest root whose square times the slot count covers the sum
      lo_root = 0;
      hi_root = 8192;
      while (lo_root < hi_root) begin
         mid = (lo_root + hi_root) / 2;
         if (mid * mid * mdd_pkg::NUM_SLOTS >= squares) hi_root = mid;
         else lo_root = mid + 1;
      end
      spread_now = int'(lo_root);
      low_now    = lo;
      high_now   = hi;
      floor_edge = lo - gain_now * spread_now;
      ceil_edge  = hi + gain_now * spread_now;
   endtask

   function automatic detector_result_type snapshot(logic kind, logic disturbed,
                                                    logic start);
      detector_result_type r;
      r.kind        = kind;
      r.reading     = mdd_pkg::DATA_BITS'(latest_reading);
      r.disturbance = disturbed;
      r.starting_up = start;
      r.mean_value  = mdd_pkg::DATA_BITS'(mean_now);
      r.deviation   = mdd_pkg::DATA_BITS'(spread_now);
      r.min_value   = mdd_pkg::DATA_BITS'(low_now);
      r.max_value   = mdd_pkg::DATA_BITS'(high_now);
      r.band_low    = mdd_pkg::EDGE_BITS'(floor_edge);
      r.band_high   = mdd_pkg::EDGE_BITS'(ceil_edge);
      return r;
   endfunction

   // Advance the predicted state by one request
   task automatic predict_request(input logic [mdd_pkg::OPCODE_BITS-1:0] op,
                                  input logic signed [mdd_pkg::DATA_BITS-1:0] z,
                                  output bit produced, output detector_result_type res);
      logic disturbed;
      produced = 1'b0;
      res      = snapshot(mdd_pkg::KIND_READING, 1'b0, 1'b0);
      case (op)
         mdd_pkg::OP_SAMPLE: begin
            group_sum += z;
            group_count++;
            if (group_count == mdd_pkg::SAMPLES) begin
               latest_reading = group_sum / mdd_pkg::SAMPLES;
               group_sum      = 0;
               group_count    = 0;
               produced       = 1'b1;
               if (in_startup) begin
                  ring[write_slot] = latest_reading;
                  write_slot = (write_slot + 1) % mdd_pkg::NUM_SLOTS;
                  fill_total++;
                  if (fill_total >= mdd_pkg::NUM_SLOTS) begin
                     refresh_statistics();
                     in_startup = 1'b0;
                     ring_full  = 1'b1;
                     fill_total = 0;
                  end
                  res = snapshot(mdd_pkg::KIND_READING, 1'b0, 1'b1);
               end else begin
                  disturbed = (floor_edge < latest_reading && latest_reading < ceil_edge)
                              ? 1'b0 : 1'b1;
                  if (floor_edge <= latest_reading && latest_reading <= ceil_edge) begin
                     ring[write_slot] = latest_reading;
                     write_slot = (write_slot + 1) % mdd_pkg::NUM_SLOTS;
                  end
                  res = snapshot(mdd_pkg::KIND_READING, disturbed, 1'b0);
               end
            end
         end
         mdd_pkg::OP_RECOMPUTE: begin
            refresh_statistics();
            produced = 1'b1;
            res = snapshot(mdd_pkg::KIND_STATS, 1'b0, in_startup);
         end
         mdd_pkg::OP_RESTART: begin
            in_startup     = 1'b1;
            write_slot     = 0;
            fill_total     = 0;
            group_sum      = 0;
            group_count    = 0;
            latest_reading = 0;
            mean_now       = 0;
            spread_now     = 0;
         end
         default: ;
      endcase
   endtask

   // Present one request, hold it until taken, then queue its result
   task automatic send_request(input logic [mdd_pkg::OPCODE_BITS-1:0] op, input int z,
                               input bit typed = 1'b0, input int value = 0);
      bit produced;
      detector_result_type res;
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(mdd_pkg::REQ_DATA_BITS - mdd_pkg::DATA_BITS){1'b0}},
                     z[mdd_pkg::DATA_BITS-1:0]};
      do @(posedge clock); while (!req_tready);
      predict_request(op, z[mdd_pkg::DATA_BITS-1:0], produced, res);
      if (produced) begin
         if (typed) begin
            res = snapshot(mdd_pkg::KIND_READING, 1'b0, 1'b1);
            res.reading = mdd_pkg::DATA_BITS'(value);
         end
         pending_results.push_back(res);
      end
   endtask

   // Hold off the sender until every expected result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(input int g);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g[mdd_pkg::GAIN_BITS-1:0];
      gain_now = g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int jitter(int w);
      return int'($urandom_range(2 * w)) - w;
   endfunction

   function automatic int bound(int v);
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      return v;
   endfunction

   // Mostly aligned groups of eight aimed at the band, some noise
   task automatic random_traffic(input int item_goal);
      int sent;
      int pick;
      int target;
      int width;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 82) begin
            width = 0;
            case ($urandom_range(3))
               0: target = int'($urandom_range(SAMPLE_MAX - SAMPLE_MIN)) + SAMPLE_MIN;
               1: begin
                  target = mean_now + jitter(gain_now * spread_now + 40);
                  width  = 8;
               end
               2: target = ($urandom_range(1) ? floor_edge : ceil_edge) + jitter(1);
               default: target = low_now + int'($urandom_range(high_now - low_now));
            endcase
            for (int k = 0; k < mdd_pkg::SAMPLES; k++)
               send_request(mdd_pkg::OP_SAMPLE, bound(target + jitter(width)));
            sent += mdd_pkg::SAMPLES;
         end else if (pick < 88) begin
            // never scan slots that were not written yet
            if (ring_full) begin
               send_request(mdd_pkg::OP_RECOMPUTE, $urandom);
               sent++;
            end
         end else if (pick < 90) begin
            send_request(mdd_pkg::OP_RESTART, $urandom);
            sent++;
         end else if (pick < 93) begin
            send_request(OP_UNUSED, $urandom);
         end else begin
            repeat ($urandom_range(1, mdd_pkg::SAMPLES - 1)) begin
               send_request(mdd_pkg::OP_SAMPLE,
                            int'($urandom_range(SAMPLE_MAX - SAMPLE_MIN)) + SAMPLE_MIN);
               sent++;
            end
         end
      end
   endtask

   function automatic string describe(detector_result_type r);
      return $sformatf({"kind %0d reading %0d dist %0d start %0d mean %0d dev %0d ",
                        "min %0d max %0d band %0d..%0d"},
                       r.kind, r.reading, r.disturbance, r.starting_up, r.mean_value,
                       r.deviation, r.min_value, r.max_value, r.band_low, r.band_high);
   endfunction

   // Compare a returned result with the oldest expectation
   task automatic check_response();
      detector_result_type got;
      detector_result_type want;
      string bad;
      got.kind        = rsp_tuser;
      got.reading     = rsp_tdata[0 +: mdd_pkg::DATA_BITS];
      got.disturbance = rsp_tdata[mdd_pkg::RSP_DIST_BIT];
      got.starting_up = rsp_tdata[mdd_pkg::RSP_START_BIT];
      got.mean_value  = rsp_tdata[MEAN_LSB +: mdd_pkg::DATA_BITS];
      got.deviation   = rsp_tdata[DEV_LSB +: mdd_pkg::DATA_BITS];
      got.min_value   = rsp_tdata[MIN_LSB +: mdd_pkg::DATA_BITS];
      got.max_value   = rsp_tdata[MAX_LSB +: mdd_pkg::DATA_BITS];
      got.band_low    = rsp_tdata[BLOW_LSB +: mdd_pkg::EDGE_BITS];
      got.band_high   = rsp_tdata[BHIGH_LSB +: mdd_pkg::EDGE_BITS];
      if (pending_results.size() == 0) begin
         if (fault_count < MAX_REPORTS)
            $display("unexpected result: %s", describe(got));
         fault_count++;
         return;
      end
      want = pending_results.pop_front();
      bad = "";
      if (got.kind !== want.kind) bad = {bad, " kind"};
      if (got.reading !== want.reading) bad = {bad, " reading"};
      if (got.disturbance !== want.disturbance) bad = {bad, " disturbance"};
      if (got.starting_up !== want.starting_up) bad = {bad, " starting_up"};
      if (got.mean_value !== want.mean_value) bad = {bad, " mean"};
      if (got.deviation !== want.deviation) bad = {bad, " deviation"};
      if (got.min_value !== want.min_value) bad = {bad, " min"};
      if (got.max_value !== want.max_value) bad = {bad, " max"};
      if (got.band_low !== want.band_low) bad = {bad, " band_low"};
      if (got.band_high !== want.band_high) bad = {bad, " band_high"};
      if (bad != "") begin
         if (fault_count < MAX_REPORTS) begin
            $display("mismatch in%s", bad);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
         end
         fault_count++;
      end
   endtask

   // Check results as they are taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_response();
   end

   // Random receiver stalls
   always @(posedge clock) begin
      rsp_tready <= (rsp_stall == 0) || ($urandom_range(99) >= rsp_stall);
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int send_plan[4];
      int stall_plan[4];
      int gain_plan[4];
      send_plan  = '{0, 74, 0, 18};
      stall_plan = '{0, 0, 74, 18};
      gain_plan  = '{15, 0, int'($urandom_range(1, 14)), 2};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= mdd_pkg::OP_SAMPLE;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed script at the reset gain
      foreach (script[r]) begin
         for (int k = 0; k < script[r].reps; k++)
            send_request(script[r].op, script[r].z, script[r].typed, script[r].value);
      end

      // Random phases, each with its own gain and idling
      for (int p = 0; p < 4; p++) begin
         drain();
         write_gain(gain_plan[p]);
         send_idle = send_plan[p];
         rsp_stall = stall_plan[p];
         random_traffic(PHASE_ITEMS);
      end

      drain();
      if (fault_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/mdd_pkg.sv
hw/rtl/mdd_isqrt.sv
hw/rtl/magnetic_disturbance_detector.sv
hw/rtl/mdd_checker.sv
bench/magnetic_disturbance_detector_test.sv
